// File: sv/dsc_pkg.sv
// Shared types, constants and helper functions of the distinct subsequence counter.
package dsc_pkg;

    // Field widths of the input and result transactions.
    localparam int unsigned VALUE_W = 10;
    localparam int unsigned COUNT_W = 30;

    // Fraction bits of the reciprocal used to fold values onto a smaller table.
    localparam int unsigned RECIP_W = 2 * VALUE_W;

    // Default size of the per-value table.
    localparam int unsigned VALUE_COUNT_DEF = 1024;

    // The prime that all sums are reduced by.
    localparam logic [COUNT_W-1:0] PRIME = 30'd1000000007;

    // Sequence tag stored with each table entry; tag zero marks a cleared entry.
    localparam int unsigned EPOCH_W = 12;

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [EPOCH_W-1:0] t_epoch;

    localparam t_epoch EPOCH_FIRST = t_epoch'(1);
    localparam t_epoch EPOCH_MAX   = '1;

    // One table entry: the sequence it belongs to and the stored prefix total.
    typedef struct packed {
        t_epoch tag;
        t_count prefix;
    } t_entry;

    // What the table says about the value of the item being counted.
    typedef struct packed {
        logic   seen;
        t_count prefix;
    } t_lookup;

    // Table maintenance mode.
    typedef enum logic {
        MODE_CLEAR,
        MODE_RUN
    } t_mode;

    // Remainder of a narrow value by a table size below 2**VALUE_W. The quotient comes from
    // a multiplication by the rounded-down reciprocal and is at most one short, so a single
    // compare and subtract finishes the remainder.
    function automatic logic [VALUE_W-1:0] fold_value(
        input logic [VALUE_W-1:0] value,
        input logic [VALUE_W-1:0] count,
        input logic [RECIP_W-1:0] recip
    );
        logic [VALUE_W+RECIP_W-1:0] prod;
        logic [VALUE_W-1:0]         quot;
        logic [2*VALUE_W-1:0]       back;
        logic [VALUE_W-1:0]         rem;
        prod = (VALUE_W + RECIP_W)'(value) * (VALUE_W + RECIP_W)'(recip);
        quot = prod[VALUE_W+RECIP_W-1:RECIP_W];
        back = (2 * VALUE_W)'(quot) * (2 * VALUE_W)'(count);
        rem  = value - back[VALUE_W-1:0];
        if (rem >= count) begin
            rem = rem - count;
        end
        return rem;
    endfunction

endpackage

// File: sv/dsc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module dsc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; returns the old contents on a same-address write.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: sv/dsc_mod_update.sv
// Modular update of the running total for one element.
module dsc_mod_update (
    input  dsc_pkg::t_count  i_total,
    input  logic             i_seq_open,
    input  dsc_pkg::t_lookup i_lookup,
    output dsc_pkg::t_count  o_base,
    output dsc_pkg::t_count  o_new_total
);

    localparam int unsigned SUM_W = dsc_pkg::COUNT_W + 3;

    logic [SUM_W-1:0] w_double;
    logic [SUM_W-1:0] w_addend;
    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0] w_sum_up;
    logic [SUM_W-1:0] w_sum_down;

    // A new sequence starts counting from zero.
    assign o_base = i_seq_open ? i_total : '0;

    // The new total is 2T+1 for a fresh value and 2T-prefix for a repeated one.
    assign w_double = SUM_W'(o_base) << 1;
    assign w_addend = i_lookup.seen ? (~SUM_W'(i_lookup.prefix) + SUM_W'(1)) : SUM_W'(1);
    assign w_sum    = w_double + w_addend;

    // The sum lies in (-P, 2P), so one correction by P in either direction suffices.
    assign w_sum_up   = w_sum + SUM_W'(dsc_pkg::PRIME);
    assign w_sum_down = w_sum - SUM_W'(dsc_pkg::PRIME);

    always_comb begin
        priority if (w_sum[SUM_W-1]) begin
            o_new_total = w_sum_up[dsc_pkg::COUNT_W-1:0];
        end else if (!w_sum_down[SUM_W-1]) begin
            o_new_total = w_sum_down[dsc_pkg::COUNT_W-1:0];
        end else begin
            o_new_total = w_sum[dsc_pkg::COUNT_W-1:0];
        end
    end

endmodule

// File: sv/dsc_out_queue.sv
// Two-entry result queue: output register plus skid entry.
module dsc_out_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dsc_pkg::t_count i_push_data,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output dsc_pkg::t_count o_out_data,
    output logic            o_room
);

    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;
    dsc_pkg::t_count r_head;
    dsc_pkg::t_count r_tail;
    logic            w_pop;
    logic [2:0]      w_after;

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_head;
    assign w_pop       = o_out_valid && i_out_ready;

    // Room for one more result after this cycle's push and pop.
    assign w_after = 3'(r_cnt) + 3'(i_push) - 3'(w_pop);
    assign o_room  = (w_after < 3'd2);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Occupancy count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Entry data moves toward the head as transactions leave.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_cnt == 2'd2) begin
                r_head <= r_tail;
                if (i_push) begin
                    r_tail <= i_push_data;
                end
            end else if (i_push) begin
                r_head <= i_push_data;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_head <= i_push_data;
            end else begin
                r_tail <= i_push_data;
            end
        end
    end

endmodule

// File: sv/distinct_subsequence_counter_top.sv
// Top level of the distinct subsequence counter.
//
// Input channel (i_valid/o_ready) takes one sequence element per transaction;
// i_last_element marks the final element of a sequence. The output channel
// (o_valid/i_ready) delivers one count, modulo 1000000007, for each sequence,
// computed in stage one and registered in the result queue after its last
// element is accepted. One element is accepted per cycle while o_ready is high.
// Each element reads the value table when it is accepted and does the modular
// update plus the table write in stage one; a same-value element right behind
// takes the written entry through a bypass register, so the table port sets
// no limit on the rate. Table entries carry a sequence tag instead of a seen
// bit. After reset the block runs a clearing pass over every table entry with
// o_ready low; the same pass runs again after every 4095 sequences, when the
// tag range is used up. A receiver stall is absorbed by a two-entry result
// queue; o_ready drops only when the queue could not hold one more result.
module distinct_subsequence_counter_top #(
    parameter int unsigned VALUE_COUNT = dsc_pkg::VALUE_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dsc_pkg::VALUE_W-1:0]   i_element_value,
    input  logic                          i_last_element,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dsc_pkg::COUNT_W-1:0]   o_subsequence_count
);

    localparam int unsigned SLOT_W = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(VALUE_COUNT - 1);

    logic               w_accept;
    logic [SLOT_W-1:0]  w_slot;

    logic               r_s1_valid;
    logic               r_s1_last;
    logic [SLOT_W-1:0]  r_s1_slot;
    logic               r_fwd_hit;
    dsc_pkg::t_entry    r_fwd_entry;

    dsc_pkg::t_entry    w_rd_entry;
    dsc_pkg::t_entry    w_sel_entry;
    dsc_pkg::t_entry    w_wr_entry;
    dsc_pkg::t_lookup   w_lookup;
    dsc_pkg::t_count    w_base;
    dsc_pkg::t_count    w_new_total;

    dsc_pkg::t_count    r_total;
    logic               r_seq_open;

    dsc_pkg::t_mode     r_mode;
    dsc_pkg::t_mode     n_mode;
    logic [SLOT_W-1:0]  r_clr_addr;
    logic [SLOT_W-1:0]  n_clr_addr;
    dsc_pkg::t_epoch    r_epoch;
    dsc_pkg::t_epoch    n_epoch;
    logic               w_clr_we;

    logic               w_close;
    logic               w_wrap_hold;
    logic               w_q_room;
    logic               w_we;
    logic [SLOT_W-1:0]  w_waddr;
    dsc_pkg::t_entry    w_wdata;

    // Map the element value onto a table slot.
    if (VALUE_COUNT >= (1 << dsc_pkg::VALUE_W)) begin : g_slot_wide
        assign w_slot = SLOT_W'(i_element_value);
    end else if ((VALUE_COUNT & (VALUE_COUNT - 1)) == 0) begin : g_slot_mask
        assign w_slot = i_element_value[SLOT_W-1:0];
    end else begin : g_slot_fold
        localparam int unsigned RECIP_INT = (32'd1 << dsc_pkg::RECIP_W) / VALUE_COUNT;
        localparam logic [dsc_pkg::VALUE_W-1:0] FOLD_COUNT =
            VALUE_COUNT[dsc_pkg::VALUE_W-1:0];
        localparam logic [dsc_pkg::RECIP_W-1:0] FOLD_RECIP =
            RECIP_INT[dsc_pkg::RECIP_W-1:0];
        logic [dsc_pkg::VALUE_W-1:0] w_folded;
        assign w_folded = dsc_pkg::fold_value(i_element_value, FOLD_COUNT, FOLD_RECIP);
        assign w_slot   = w_folded[SLOT_W-1:0];
    end

    // Input handshake.
    assign w_close     = r_s1_valid && r_s1_last;
    assign w_wrap_hold = w_close && (r_epoch == dsc_pkg::EPOCH_MAX);
    assign o_ready     = (r_mode == dsc_pkg::MODE_RUN) && !w_wrap_hold && w_q_room;
    assign w_accept    = i_valid && o_ready;

    // Table maintenance: clearing pass and sequence tag advance.
    always_comb begin
        n_mode     = r_mode;
        n_clr_addr = r_clr_addr;
        n_epoch    = r_epoch;
        w_clr_we   = 1'b0;
        unique case (r_mode)
            dsc_pkg::MODE_CLEAR: begin
                w_clr_we   = 1'b1;
                n_clr_addr = r_clr_addr + SLOT_W'(1);
                if (r_clr_addr == SLOT_LAST) begin
                    n_mode     = dsc_pkg::MODE_RUN;
                    n_clr_addr = '0;
                    n_epoch    = dsc_pkg::EPOCH_FIRST;
                end
            end
            dsc_pkg::MODE_RUN: begin
                if (w_close) begin
                    if (r_epoch == dsc_pkg::EPOCH_MAX) begin
                        n_mode = dsc_pkg::MODE_CLEAR;
                    end else begin
                        n_epoch = r_epoch + dsc_pkg::t_epoch'(1);
                    end
                end
            end
            default: begin
                n_mode = dsc_pkg::MODE_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= dsc_pkg::MODE_CLEAR;
            r_clr_addr <= '0;
            r_epoch    <= dsc_pkg::EPOCH_FIRST;
        end else begin
            r_mode     <= n_mode;
            r_clr_addr <= n_clr_addr;
            r_epoch    <= n_epoch;
        end
    end

    // Stage one holds the accepted element while its table entry is read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last   <= i_last_element;
        r_s1_slot   <= w_slot;
        r_fwd_hit   <= r_s1_valid && (r_s1_slot == w_slot);
        r_fwd_entry <= w_wr_entry;
    end

    // Value table.
    assign w_wr_entry = '{tag: r_epoch, prefix: w_base};
    assign w_we       = w_clr_we || r_s1_valid;
    assign w_waddr    = w_clr_we ? r_clr_addr : r_s1_slot;
    assign w_wdata    = w_clr_we ? '0 : w_wr_entry;

    dsc_ram #(
        .WIDTH ($bits(dsc_pkg::t_entry)),
        .DEPTH (VALUE_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_slot),
        .o_rdata (w_rd_entry)
    );

    // An entry written in the cycle of the read is taken from the bypass register.
    assign w_sel_entry     = r_fwd_hit ? r_fwd_entry : w_rd_entry;
    assign w_lookup.seen   = (w_sel_entry.tag == r_epoch);
    assign w_lookup.prefix = w_sel_entry.prefix;

    dsc_mod_update u_update (
        .i_total     (r_total),
        .i_seq_open  (r_seq_open),
        .i_lookup    (w_lookup),
        .o_base      (w_base),
        .o_new_total (w_new_total)
    );

    // Running total and sequence state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_seq_open <= 1'b0;
        end else if (r_s1_valid) begin
            r_total    <= w_new_total;
            r_seq_open <= !r_s1_last;
        end
    end

    // Result queue toward the output channel.
    dsc_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_close),
        .i_push_data (w_new_total),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_out_data  (o_subsequence_count),
        .o_room      (w_q_room)
    );

endmodule

// File: sv/dsc_checker.sv
// Port-level checker for the distinct subsequence counter, bound to the top level.
module dsc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic [dsc_pkg::VALUE_W-1:0]   i_element_value,
    input logic                          i_last_element,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [dsc_pkg::COUNT_W-1:0]   o_subsequence_count
);

    // A stalled result transaction holds its count.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_subsequence_count))
        else $error("result changed while stalled");

    // Every count is reduced below the prime.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_subsequence_count < dsc_pkg::PRIME))
        else $error("count not reduced");

    // The table clearing pass keeps the input closed right after reset.
    a_reset_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("input open during clearing pass");

    // A result shows up in an empty queue only after an accepted last element passes stage one.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready && i_last_element, 2))
        else $error("result without a last element");

endmodule

bind distinct_subsequence_counter_top dsc_checker u_dsc_checker (.*);
